// ----- hw/rtl/bounded_integer_set_table_core_assert.svh -----
// assertion macros for the bounded integer set table
// used by the top level; no other dependencies
`ifndef BOUNDED_INTEGER_SET_TABLE_CORE_ASSERT_SVH
`define BOUNDED_INTEGER_SET_TABLE_CORE_ASSERT_SVH

// property must hold at every edge out of reset
`define BIST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition implies a consequence in the next cycle
`define BIST_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);

// condition implies a consequence in the same cycle
`define BIST_ASSERT_SAME(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |-> post) else $error(msg);

`endif

// ----- hw/rtl/bist_pkg.sv -----
// shared types and constants of the bounded integer set table
// no dependencies; compiled before the interfaces and modules
package bist_pkg;

  // default number of cells
  localparam int unsigned DefaultDepth = 64;

  // fixed field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StW     = 2;
  localparam int unsigned CntOutW = 7;
  localparam int unsigned CapW    = 7;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_QUERY  = 3'd2,
    OP_REWIND = 3'd3,
    OP_NEXT   = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_END  = 2'd3
  } status_e;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rm_en;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/bist_req_if.sv -----
// request channel of the set table: op and value with valid/ready
// depends on bist_pkg
interface bist_req_if;
  import bist_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic signed [ValW-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- hw/rtl/bist_rsp_if.sv -----
// response channel of the set table: status, element and count with valid/ready
// depends on bist_pkg
interface bist_rsp_if;
  import bist_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StW-1:0]         status;
  logic signed [ValW-1:0] element;
  logic [CntOutW-1:0]     count;

  modport source (output valid, output status, output element, output count, input ready);
  modport sink   (input valid, input status, input element, input count, output ready);
endinterface

// ----- hw/rtl/bist_cell.sv -----
// one storage cell of the set table: holds one entry, compares it and shifts
// depends on bist_pkg
module bist_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bist_pkg::cell_ctrl_t            ctrl_i,
  input  logic [CntW-1:0]                 cnt_i,
  input  logic [CntW-1:0]                 cursor_i,
  input  logic signed [bist_pkg::ValW-1:0] value_i,
  input  logic                            shift_i,
  output logic                            shift_o,
  input  logic signed [bist_pkg::ValW-1:0] nbr_i,
  output logic signed [bist_pkg::ValW-1:0] entry_o,
  output logic                            hit_o,
  output logic signed [bist_pkg::ValW-1:0] rd_o
);
  import bist_pkg::*;

  localparam logic [CntW-1:0] IdxC  = CntW'(Idx);
  localparam logic [CntW-1:0] NextC = CntW'(Idx + 1);

  logic signed [ValW-1:0] entry_q, entry_d;
  logic                   hit_q, hit_d;
  logic                   occupied;

  assign occupied = IdxC < cnt_i;

  // compare result, captured once per item
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      hit_d = occupied && (entry_q == value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // removal wave: every cell at or after the hit pulls from its right neighbor
  assign shift_o = shift_i | hit_q;

  // entry write: append at the fill point or take the neighbor's entry
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && (IdxC == cnt_i)) begin
      entry_d = value_i;
    end else if (ctrl_i.rm_en && shift_o && (NextC < cnt_i)) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;
  assign rd_o    = (IdxC == cursor_i) ? entry_q : '0;

endmodule

// ----- hw/rtl/bounded_integer_set_table_core.sv -----
// top level of the bounded integer set table: control, counters and the cell row
// depends on bist_pkg, bist_req_if, bist_rsp_if, bist_cell and the assertion header
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------
//  req_i    | in  | valid/ready  | op[2:0], value[31:0] signed
//  rsp_o    | out | valid/ready  | status[1:0], element[31:0], count[6:0]
//  cfg      | in  | cfg_we_i     | cfg_data_i[6:0] = capacity
//
// every item passes through S_CMP, the parallel compare in all cells, and then S_UPD, which
// updates the cells and the counters; the next item is taken in the update state.
// the update waits while the previous result is still held in the output register.
// reset clears the count, the cursor and the control; entries hold no reset value.
// removal shifts every later entry one cell down in the update cycle.
`include "bounded_integer_set_table_core_assert.svh"

module bounded_integer_set_table_core #(
  parameter int unsigned DEPTH = bist_pkg::DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bist_pkg::CapW-1:0]  cfg_data_i,
  bist_req_if.sink                   req_i,
  bist_rsp_if.source                 rsp_o
);
  import bist_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned LimW = (CntW > CapW) ? CntW : CapW;
  localparam logic [LimW-1:0] DepthL = LimW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e                 state_q;
  logic [OpW-1:0]         op_q;
  logic signed [ValW-1:0] value_q;
  logic [CapW-1:0]        cap_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        cursor_q, cursor_d;
  logic                   out_valid_q;
  logic [StW-1:0]         status_q;
  logic signed [ValW-1:0] element_q;
  logic [CntOutW-1:0]     count_q;

  logic                   commit;
  logic                   in_ready;
  logic                   any_hit;
  logic                   room;
  logic                   cur_ok;
  status_e                status_d;
  logic signed [ValW-1:0] element_d;
  logic signed [ValW-1:0] sel_elem;
  cell_ctrl_t             ctrl;

  logic [DEPTH-1:0]       hit_w;
  logic [DEPTH:0]         shift_w;
  logic signed [ValW-1:0] entry_w [DEPTH+1];
  logic signed [ValW-1:0] rd_w    [DEPTH];
  logic [DEPTH-1:0]       rd_bits [ValW];

  // handshake
  assign commit   = (state_q == S_UPD) && (!out_valid_q || rsp_o.ready);
  assign in_ready = (state_q == S_IDLE) || commit;
  assign req_i.ready = in_ready;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // cell row
  assign shift_w[0]     = 1'b0;
  assign entry_w[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bist_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .cnt_i    (cnt_q),
      .cursor_i (cursor_q),
      .value_i  (value_q),
      .shift_i  (shift_w[i]),
      .shift_o  (shift_w[i+1]),
      .nbr_i    (entry_w[i+1]),
      .entry_o  (entry_w[i]),
      .hit_o    (hit_w[i]),
      .rd_o     (rd_w[i])
    );
    for (genvar b = 0; b < ValW; b++) begin : g_bit
      assign rd_bits[b][i] = rd_w[i][b];
    end
  end

  // read selection: the cell at the cursor drives its entry, the rest drive zero
  for (genvar b = 0; b < ValW; b++) begin : g_sel
    assign sel_elem[b] = |rd_bits[b];
  end

  assign any_hit = |hit_w;
  assign room    = (LimW'(cnt_q) < LimW'(cap_q)) && (LimW'(cnt_q) < DepthL);
  assign cur_ok  = cursor_q < cnt_q;

  // commands to the cells
  always_comb begin
    ctrl.cmp_en = (state_q == S_CMP);
    ctrl.ins_en = commit && (op_q == OP_INSERT) && !any_hit && room;
    ctrl.rm_en  = commit && (op_q == OP_REMOVE) && any_hit;
  end

  // result and counter update
  always_comb begin
    status_d  = ST_OK;
    element_d = '0;
    cnt_d     = cnt_q;
    cursor_d  = cursor_q;
    case (op_q)
      OP_INSERT: begin
        if (any_hit) begin
          status_d = ST_MISS;
        end else if (!room) begin
          status_d = ST_FULL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          status_d = ST_MISS;
        end
      end
      OP_QUERY: begin
        if (!any_hit) begin
          status_d = ST_MISS;
        end
      end
      OP_REWIND: begin
        cursor_d = '0;
      end
      OP_NEXT: begin
        if (cur_ok) begin
          element_d = sel_elem;
          cursor_d  = cursor_q + 1'b1;
        end else begin
          status_d = ST_END;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (commit) begin
            cnt_q    <= cnt_d;
            cursor_q <= cursor_d;
            state_q  <= req_i.valid ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and result payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      op_q    <= req_i.op;
      value_q <= req_i.value;
    end
    if (commit) begin
      status_q  <= status_d;
      element_q <= element_d;
      count_q   <= CntOutW'(cnt_d);
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.element = element_q;
  assign rsp_o.count   = count_q;

  // checks
  `BIST_ASSERT(a_cnt_bound, clk_i, rst_ni, (cnt_q <= CntW'(DEPTH)), "count above depth")
  `BIST_ASSERT_SAME(a_hit_unique, clk_i, rst_ni, (state_q == S_UPD), $onehot0(hit_w), "several cells hit")
  `BIST_ASSERT_SAME(a_wave_end, clk_i, rst_ni, (state_q == S_UPD), (shift_w[DEPTH] == any_hit), "removal wave lost")
  `BIST_ASSERT_NEXT(a_ins_grow, clk_i, rst_ni, ctrl.ins_en, (cnt_q == CntW'($past(cnt_q) + 1'b1)), "insert did not grow count")
  `BIST_ASSERT_SAME(a_rsp_src, clk_i, rst_ni, $rose(out_valid_q), $past(commit), "result without update")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for bounded_integer_set_table_core: directed rows, then random phases
// depends on bist_pkg, bist_req_if, bist_rsp_if and the core with its assertion header
module testbench;
  import bist_pkg::*;

  localparam int unsigned Depth        = DefaultDepth;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PhaseItems   = 94;
  localparam int unsigned PoolSize     = 96;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned SettleCycles = 8;

  // op codes the core leaves unused
  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  typedef enum logic [1:0] {
    GAP_NONE,
    GAP_SEND,
    GAP_RECV,
    GAP_BOTH
  } gap_mode_e;

  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] element;
    logic [CntOutW-1:0]     count;
  } set_result_t;

  typedef struct {
    bit              is_cfg;
    logic [CapW-1:0] cap;
    logic [OpW-1:0]  op;
    logic [ValW-1:0] value;
    bit              typed;
    set_result_t     res;
  } step_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CapW-1:0] cfg_data_i;

  bist_req_if req_if ();
  bist_rsp_if rsp_if ();

  bounded_integer_set_table_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow copy of the set
  logic [ValW-1:0]    set_entries [Depth];
  logic [CntOutW-1:0] set_count;
  logic [CntOutW-1:0] trav_cursor;
  logic [CapW-1:0]    cap_reg;

  set_result_t     expected_results [$];
  step_row_t       directed_rows [$];
  logic [ValW-1:0] value_pool [PoolSize];
  gap_mode_e       gap_mode;
  bit              hold_pending;
  int unsigned     hold_left;
  int unsigned     idle_cycles;
  int unsigned     errors;

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // apply one operation to the shadow set and return its result
  function automatic set_result_t apply_set_op(logic [OpW-1:0] op, logic [ValW-1:0] v);
    set_result_t r;
    int unsigned slot;
    int unsigned limit;
    int unsigned i;
    r.status  = ST_OK;
    r.element = '0;
    limit = (cap_reg < Depth) ? cap_reg : Depth;
    slot = set_count;
    for (i = 0; i < set_count; i++) begin
      if (set_entries[i] == v && slot == set_count) slot = i;
    end
    case (op)
      OP_INSERT: begin
        if (slot < set_count) r.status = ST_MISS;
        else if (set_count >= limit) r.status = ST_FULL;
        else begin
          set_entries[set_count] = v;
          set_count++;
        end
      end
      OP_REMOVE: begin
        if (slot < set_count) begin
          for (i = slot; i + 1 < set_count; i++) set_entries[i] = set_entries[i+1];
          set_count--;
        end else begin
          r.status = ST_MISS;
        end
      end
      OP_QUERY: begin
        if (slot >= set_count) r.status = ST_MISS;
      end
      OP_REWIND: begin
        trav_cursor = '0;
      end
      OP_NEXT: begin
        if (trav_cursor < set_count) begin
          r.element = set_entries[trav_cursor];
          trav_cursor++;
        end else begin
          r.status = ST_END;
        end
      end
      default: begin
      end
    endcase
    r.count = set_count;
    return r;
  endfunction

  function automatic bit sender_waits();
    case (gap_mode)
      GAP_SEND: return $urandom_range(99) < 73;
      GAP_BOTH: return $urandom_range(99) < 6;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (gap_mode)
      GAP_RECV: return $urandom_range(99) < 73;
      GAP_BOTH: return $urandom_range(99) < 6;
      default:  return 1'b0;
    endcase
  endfunction

  // directed table rows
  function automatic void row_cfg(logic [CapW-1:0] cap);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cap    = cap;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_pred(logic [OpW-1:0] op, logic [ValW-1:0] v);
    step_row_t row;
    row = '{default: '0};
    row.op    = op;
    row.value = v;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_chk(logic [OpW-1:0] op, logic [ValW-1:0] v, status_e st,
                                  logic [ValW-1:0] elem, logic [CntOutW-1:0] cnt);
    step_row_t row;
    row = '{default: '0};
    row.op          = op;
    row.value       = v;
    row.typed       = 1'b1;
    row.res.status  = st;
    row.res.element = elem;
    row.res.count   = cnt;
    directed_rows.push_back(row);
  endfunction

  // offer one item, then record its expected result once it is taken
  task automatic offer_item(input logic [OpW-1:0] op, input logic [ValW-1:0] v,
                            input bit typed, input set_result_t typed_res);
    set_result_t pred;
    while (sender_waits()) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.value <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = apply_set_op(op, v);
    expected_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // capacity is only written with the core idle
  task automatic write_capacity(input logic [CapW-1:0] cap);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cap_reg = cap;
    cfg_we_i <= 1'b0;
  endtask

  // response side: check each item, then pick ready for the next cycle
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item pending: status %0d element %h count %0d",
                 $time, rsp_if.status, rsp_if.element, rsp_if.count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.element !== want.element) begin
          $display("%0t: element mismatch, expected %h, actual %h",
                   $time, want.element, rsp_if.element);
          errors++;
        end
        if (rsp_if.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d",
                   $time, want.count, rsp_if.count);
          errors++;
        end
      end
    end
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !receiver_stalls();
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, StallLimit);
      $display("** bounded_integer_set_table_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CapW-1:0] phase_caps [PhaseCount];
    logic [OpW-1:0]  op;
    logic [ValW-1:0] v;
    int unsigned     phase;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     ins_w;
    int unsigned     rm_w;
    int unsigned     pool_n;

    // every input known from time zero
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = CapReset;
    req_if.valid  = 1'b0;
    req_if.op     = OP_INSERT;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    gap_mode      = GAP_NONE;
    hold_pending  = 1'b0;
    hold_left     = 0;
    idle_cycles   = 0;
    errors        = 0;
    set_count     = '0;
    trav_cursor   = '0;
    cap_reg       = CapReset;

    phase_caps = '{7'd64, 7'd127, 7'd64, 7'd3, 7'd0, 7'd10,
                   7'd1, 7'd100, 7'd64, 7'd32, 7'd2, 7'd65};

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (n = 4; n < PoolSize; n++) value_pool[n] = $urandom;

    // empty set, then the value extremes
    row_chk(OP_NEXT,   32'h0000_0000, ST_END,  32'h0, 7'd0);
    row_chk(OP_QUERY,  32'h0000_0000, ST_MISS, 32'h0, 7'd0);
    row_chk(OP_REMOVE, 32'h0000_0005, ST_MISS, 32'h0, 7'd0);
    row_chk(OP_INSERT, 32'h8000_0000, ST_OK,   32'h0, 7'd1);
    row_chk(OP_INSERT, 32'h7fff_ffff, ST_OK,   32'h0, 7'd2);
    row_chk(OP_INSERT, 32'hffff_ffff, ST_OK,   32'h0, 7'd3);
    row_chk(OP_INSERT, 32'h0000_0000, ST_OK,   32'h0, 7'd4);
    // duplicate insert and a hit
    row_chk(OP_INSERT, 32'h7fff_ffff, ST_MISS, 32'h0, 7'd4);
    row_chk(OP_QUERY,  32'hffff_ffff, ST_OK,   32'h0, 7'd4);
    // traversal across a removal, cursor left past the count
    row_chk(OP_NEXT,   32'h0000_0000, ST_OK,   32'h8000_0000, 7'd4);
    row_pred(OP_NEXT,  32'hdead_beef);
    row_chk(OP_REMOVE, 32'h8000_0000, ST_OK,   32'h0, 7'd3);
    row_pred(OP_NEXT,  32'h0000_0000);
    row_chk(OP_NEXT,   32'h0000_0000, ST_END,  32'h0, 7'd3);
    row_chk(OP_REMOVE, 32'h0000_0000, ST_OK,   32'h0, 7'd2);
    row_chk(OP_NEXT,   32'h0000_0000, ST_END,  32'h0, 7'd2);
    row_chk(OP_REWIND, 32'hffff_ffff, ST_OK,   32'h0, 7'd2);
    row_pred(OP_NEXT,  32'h0000_0000);
    // unused codes change nothing
    row_chk(OpSpare5,  32'h1234_5678, ST_OK,   32'h0, 7'd2);
    row_chk(OpSpare6,  32'ha5a5_a5a5, ST_OK,   32'h0, 7'd2);
    row_chk(OpSpare7,  32'hffff_ffff, ST_OK,   32'h0, 7'd2);
    // capacity lowered below the count
    row_cfg(7'd1);
    row_chk(OP_INSERT, 32'h0000_0001, ST_FULL, 32'h0, 7'd2);
    row_chk(OP_INSERT, 32'hffff_ffff, ST_MISS, 32'h0, 7'd2);
    row_chk(OP_REMOVE, 32'h7fff_ffff, ST_OK,   32'h0, 7'd1);
    row_chk(OP_INSERT, 32'h0000_0001, ST_FULL, 32'h0, 7'd1);
    row_cfg(7'd0);
    row_chk(OP_INSERT, 32'h0000_0002, ST_FULL, 32'h0, 7'd1);
    // capacity above the depth saturates
    row_cfg(7'd127);
    row_chk(OP_INSERT, 32'h0000_0002, ST_OK,   32'h0, 7'd2);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_capacity(directed_rows[i].cap);
      else offer_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].res);
    end

    // random phases, one capacity and one idling pattern each
    for (phase = 0; phase < PhaseCount; phase++) begin
      write_capacity(phase_caps[phase]);
      gap_mode = gap_mode_e'(phase % 4);
      // long receiver hold-off while items keep coming
      if (phase == 4) hold_pending = 1'b1;
      if (phase_caps[phase] >= 32) begin
        ins_w  = 55;
        rm_w   = 15;
        pool_n = PoolSize;
      end else begin
        ins_w  = 25;
        rm_w   = 35;
        pool_n = 8;
      end
      for (n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        if (pick < ins_w) op = OP_INSERT;
        else if (pick < ins_w + rm_w) op = OP_REMOVE;
        else if (pick < ins_w + rm_w + 12) op = OP_QUERY;
        else if (pick < ins_w + rm_w + 17) op = OP_REWIND;
        else if (pick < 98) op = OP_NEXT;
        else op = OpSpare5 + 3'($urandom_range(2));
        // mostly present members or pool values, some noise
        pick = $urandom_range(99);
        if (pick < 40 && set_count != 0) v = set_entries[$urandom_range(set_count - 1)];
        else if (pick < 85) v = value_pool[$urandom_range(pool_n - 1)];
        else v = $urandom;
        offer_item(op, v, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("** bounded_integer_set_table_core: PASSED **");
    end else begin
      $display("** bounded_integer_set_table_core: FAILED **");
    end
    $finish;
  end

endmodule
